/* hw/rtl/dfr_pkg.sv */
// Shared types and constants of the delimited frame receiver.
// No dependencies; used by dfr_ctrl and delimited_frame_receiver.
`default_nettype none

package dfr_pkg;

  typedef enum logic [1:0] {
    KIND_MSG      = 2'd0,
    KIND_OVERFLOW = 2'd1,
    KIND_NOMSG    = 2'd2
  } kind_e;

  typedef enum logic [0:0] {
    CFG_START_MARKER = 1'b0,
    CFG_END_MARKER   = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned ByteW   = 8;

  localparam logic [ByteW-1:0] StartMarkerReset = 8'hFF;
  localparam logic [ByteW-1:0] EndMarkerReset   = 8'h00;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/dfr_store.sv */
// Frame store: single-port-write, single-port-read synchronous memory.
// Read data is registered and appears in the cycle after the read enable.
`default_nettype none

module dfr_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [7:0]       wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output      logic [7:0]       rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* hw/rtl/dfr_ctrl.sv */
// Frame controller: fill level, marker tracking, readout sequencer and output register.
// Depends on dfr_pkg; drives the write and read ports of dfr_store.
`default_nettype none

module dfr_ctrl #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned CntW  = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dfr_pkg::cfg_t    cfg_i,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [7:0]       in_byte_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [7:0]       out_byte_o,
  output      dfr_pkg::kind_e   out_kind_o,
  output      logic             out_last_o,
  output      logic             wr_en_o,
  output      logic [AddrW-1:0] wr_addr_o,
  output      logic [7:0]       wr_data_o,
  output      logic             rd_en_o,
  output      logic [AddrW-1:0] rd_addr_o,
  input  wire logic [7:0]       rd_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_STATUS = 4'b0010,
    ST_READ   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             armed_q, armed_d;
  logic             early_q, early_d;
  logic [AddrW-1:0] lsi_q, lsi_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AddrW-1:0] end_q, end_d;
  dfr_pkg::kind_e   status_q, status_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  dfr_pkg::kind_e   out_kind_q, out_kind_d;
  logic             out_last_q, out_last_d;
  logic             out_load;

  logic             accept;
  logic             full;
  logic [AddrW-1:0] idx;
  logic             is_start;
  logic             is_end;
  logic             rd_last;
  logic             out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign full     = (fill_q == CntW'(Depth));
  assign idx      = fill_q[AddrW-1:0];
  assign is_start = (in_byte_i == cfg_i.start_marker);
  assign is_end   = (in_byte_i == cfg_i.end_marker);
  assign rd_last  = (({1'b0, rd_ptr_q} + (AddrW+1)'(1)) == {1'b0, end_q});
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == ST_IDLE);
  assign wr_addr_o  = idx;
  assign wr_data_o  = in_byte_i;
  assign rd_addr_o  = rd_ptr_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    armed_d    = armed_q;
    early_d    = early_q;
    lsi_d      = lsi_q;
    rd_ptr_d   = rd_ptr_q;
    end_d      = end_q;
    status_d   = status_q;
    wr_en_o    = 1'b0;
    rd_en_o    = 1'b0;
    out_load   = 1'b0;
    out_byte_d = out_byte_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            fill_d   = '0;
            armed_d  = 1'b0;
            early_d  = 1'b0;
            lsi_d    = '0;
            status_d = dfr_pkg::KIND_OVERFLOW;
            state_d  = ST_STATUS;
          end else begin
            wr_en_o = 1'b1;
            fill_d  = fill_q + CntW'(1);
            if (!armed_q) begin
              if (is_start) begin
                armed_d = 1'b1;
                lsi_d   = idx;
              end else if (is_end) begin
                early_d = 1'b1;
              end
            end else if (!is_end) begin
              if (is_start) begin
                lsi_d = idx;
              end
            end else begin
              fill_d  = '0;
              armed_d = 1'b0;
              early_d = 1'b0;
              lsi_d   = '0;
              if (early_q) begin
                status_d = dfr_pkg::KIND_NOMSG;
                state_d  = ST_STATUS;
              end else begin
                rd_ptr_d = lsi_q;
                end_d    = idx;
                state_d  = ST_READ;
              end
            end
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = '0;
          out_kind_d = status_q;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_READ: begin
        rd_en_o = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = rd_data_i;
          out_kind_d = dfr_pkg::KIND_MSG;
          out_last_d = rd_last;
          if (rd_last) begin
            state_d = ST_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q + AddrW'(1);
            state_d  = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      armed_q     <= 1'b0;
      early_q     <= 1'b0;
      lsi_q       <= '0;
      rd_ptr_q    <= '0;
      end_q       <= '0;
      status_q    <= dfr_pkg::KIND_OVERFLOW;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      armed_q     <= armed_d;
      early_q     <= early_d;
      lsi_q       <= lsi_d;
      rd_ptr_q    <= rd_ptr_d;
      end_q       <= end_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

/* hw/rtl/delimited_frame_receiver.sv */
// A status result passes through the status state and output register after its byte.
// A message is read out over the single registered read port of the frame store in read
// and emit steps; emit holds on an output stall, and the next byte is read only after it.
// Throughput: one byte per cycle while a frame fills; none is taken in readout or status.
// Reset is asynchronous and active low: it clears the fill level, marker tracking and
// output valid and restores the marker registers; store contents are left undefined.
`default_nettype none

module delimited_frame_receiver #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [dfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]               cfg_data_i,
  input  wire logic                     s_axis_tvalid,
  output      logic                     s_axis_tready,
  input  wire logic [7:0]               s_axis_tdata,   // [7:0] rx_byte
  output      logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output      logic [7:0]               m_axis_tdata,   // [7:0] out_byte
  output      logic [1:0]               m_axis_tuser,   // [1:0] kind
  output      logic                     m_axis_tlast
);

  localparam int unsigned AddrW = $clog2(STORE_DEPTH);
  localparam int unsigned CntW  = $clog2(STORE_DEPTH + 1);

  dfr_pkg::cfg_t    cfg_q;
  dfr_pkg::kind_e   out_kind;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= dfr_pkg::StartMarkerReset;
      cfg_q.end_marker   <= dfr_pkg::EndMarkerReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dfr_pkg::CFG_START_MARKER: cfg_q.start_marker <= cfg_data_i;
        dfr_pkg::CFG_END_MARKER:   cfg_q.end_marker   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dfr_ctrl #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_kind_o  (out_kind),
    .out_last_o  (m_axis_tlast),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  dfr_store #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tuser = out_kind;

  // A status result always closes the results of its byte.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != dfr_pkg::KIND_MSG) |-> m_axis_tlast)
    else $error("status result without tlast");

  // The store is never written and read in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("store write and read overlap");

  // A store write only happens on an accepted input transfer.
  a_write_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s_axis_tvalid && s_axis_tready)
    else $error("store written without input transfer");

  // No input is taken in the cycle after a readout request.
  a_read_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> !s_axis_tready)
    else $error("input accepted during readout");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for delimited_frame_receiver: random and directed byte streams
// are checked against a cycle-free predictor of the frame store. Depends on dfr_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct packed {
    logic [7:0]      data;
    dfr_pkg::kind_e  kind;
    logic            last;
  } out_xfer_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  dfr_pkg::cfg_idx_e cfg_index_i = dfr_pkg::CFG_START_MARKER;
  logic [7:0]        cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;

  delimited_frame_receiver #(.STORE_DEPTH(STORE_DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Predictor state mirrors the frame store of the block.
  logic [7:0]  frame_copy [STORE_DEPTH];
  int unsigned fill_level = 0;
  bit          armed = 1'b0;
  int unsigned start_pos = 0;
  bit          early_end = 1'b0;
  logic [7:0]  start_mk = dfr_pkg::StartMarkerReset;
  logic [7:0]  end_mk = dfr_pkg::EndMarkerReset;

  out_xfer_t   out_expected [$];
  logic [7:0]  rx_backlog [$];

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned fails = 0;
  int unsigned bytes_taken = 0;
  int unsigned msg_bytes = 0;
  int unsigned overflows = 0;
  int unsigned nomsg_frames = 0;
  int unsigned queued = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_out(input logic [7:0] data, input dfr_pkg::kind_e kind,
                                      input logic last);
    out_xfer_t x;
    x.data = data;
    x.kind = kind;
    x.last = last;
    out_expected.push_back(x);
  endfunction

  function automatic void clear_frame();
    fill_level = 0;
    armed = 1'b0;
    start_pos = 0;
    early_end = 1'b0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    int unsigned idx;
    if (fill_level >= STORE_DEPTH) begin
      clear_frame();
      predict_out('0, dfr_pkg::KIND_OVERFLOW, 1'b1);
      return;
    end
    idx = fill_level;
    frame_copy[idx] = b;
    fill_level = idx + 1;
    if (!armed) begin
      if (b == start_mk) begin
        armed = 1'b1;
        start_pos = idx;
      end else if (b == end_mk) begin
        early_end = 1'b1;
      end
    end else if (b != end_mk) begin
      if (b == start_mk) start_pos = idx;
    end else begin
      if (early_end) begin
        predict_out('0, dfr_pkg::KIND_NOMSG, 1'b1);
      end else begin
        for (int unsigned i = start_pos; i < idx; i++) begin
          predict_out(frame_copy[i], dfr_pkg::KIND_MSG, i + 1 == idx);
        end
      end
      clear_frame();
    end
  endfunction

  // Byte source.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_byte(s_axis_tdata);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= rx_backlog.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink and checker.
  always @(posedge clk_i or negedge rst_ni) begin
    out_xfer_t x;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (out_expected.size() == 0) begin
          $display("%0t: unexpected transfer data %02h kind %0d last %0b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fails++;
        end else begin
          x = out_expected.pop_front();
          if (m_axis_tdata !== x.data || m_axis_tuser !== x.kind || m_axis_tlast !== x.last) begin
            $display("%0t: expected data %02h kind %0d last %0b, actual data %02h kind %0d last %0b",
                     $time, x.data, x.kind, x.last, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fails++;
          end
          case (x.kind)
            dfr_pkg::KIND_MSG:      msg_bytes++;
            dfr_pkg::KIND_OVERFLOW: overflows++;
            default:                nomsg_frames++;
          endcase
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served <= hold_served + 1;
        hold_left <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(99) >= sink_idle_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, out_expected.size());
      $display("delimited_frame_receiver: mismatch");
      $finish;
    end
  end

  task automatic write_marker(input dfr_pkg::cfg_idx_e idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == dfr_pkg::CFG_START_MARKER) start_mk = value;
    else end_mk = value;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (rx_backlog.size() != 0 || s_axis_tvalid || out_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void push_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    queued++;
  endfunction

  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    if (start_mk != end_mk && $urandom_range(9) == 0) return start_mk;
    do b = 8'($urandom_range(255)); while (b == end_mk);
    return b;
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == end_mk || b == start_mk);
    return b;
  endfunction

  // Mostly well-formed frames with random content, plus early terminators,
  // overlong frames and raw noise.
  function automatic void push_random_frames(input int unsigned budget);
    int unsigned stop;
    int unsigned pick;
    int unsigned len;
    stop = queued + budget;
    while (queued < stop) begin
      pick = $urandom_range(99);
      if (pick < 64) begin
        repeat ($urandom_range(2)) push_byte(pick_junk());
        push_byte(start_mk);
        len = ($urandom_range(9) == 0) ? $urandom_range(62, 20) : $urandom_range(10);
        repeat (len) push_byte(pick_payload());
        push_byte(end_mk);
      end else if (pick < 76) begin
        push_byte(end_mk);
        repeat ($urandom_range(2)) push_byte(pick_junk());
        push_byte(start_mk);
        repeat ($urandom_range(5)) push_byte(pick_payload());
        push_byte(end_mk);
      end else if (pick < 79) begin
        push_byte(start_mk);
        repeat (STORE_DEPTH) push_byte(pick_payload());
      end else if (pick < 81) begin
        push_byte(start_mk);
        repeat (STORE_DEPTH - 2) push_byte(pick_payload());
        push_byte(end_mk);
      end else begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
      end
    end
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 27;
    sink_idle_pct = 76;
    write_marker(dfr_pkg::CFG_START_MARKER, 8'hFF);
    write_marker(dfr_pkg::CFG_END_MARKER, 8'h00);
    // Early terminator with noise, then moving start markers, then a one-byte message.
    push_byte(8'h00); push_byte(8'h41); push_byte(8'hFF); push_byte(8'h55); push_byte(8'h00);
    push_byte(8'hFF); push_byte(8'h12); push_byte(8'hFF); push_byte(8'hAB); push_byte(8'h80);
    push_byte(8'h00);
    push_byte(8'hFF); push_byte(8'h00);
    push_byte(8'h7F); push_byte(8'hFF); push_byte(8'h01); push_byte(8'hFE); push_byte(8'h00);
    push_random_frames(150);
    drain();

    src_idle_pct = 76;
    sink_idle_pct = 27;
    write_marker(dfr_pkg::CFG_START_MARKER, 8'h02);
    write_marker(dfr_pkg::CFG_END_MARKER, 8'h03);
    push_random_frames(150);
    drain();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_marker(dfr_pkg::CFG_START_MARKER, 8'h7E);
    write_marker(dfr_pkg::CFG_END_MARKER, 8'h7E);
    // One marker value for both: it opens when unarmed and closes when armed.
    push_byte(8'h7E); push_byte(8'h31); push_byte(8'h7E);
    hold_requests++;
    push_random_frames(80);
    drain();

    write_marker(dfr_pkg::CFG_START_MARKER, 8'h00);
    write_marker(dfr_pkg::CFG_END_MARKER, 8'hFF);
    push_random_frames(80);
    drain();

    $display("Run covered %0d bytes taken in over four marker settings and three idle mixes.",
             bytes_taken);
    $display("Results checked: %0d message bytes, %0d overflows, %0d frames without message.",
             msg_bytes, overflows, nomsg_frames);
    if (fails == 0) begin
      $display("delimited_frame_receiver: match");
    end else begin
      $display("delimited_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule
